FILE: hdl/channel_value_frame_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the channel/value frame parser
// Checks sampled on the rising edge of clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_VALUE_FRAME_PARSER_TOP_MACROS_SVH
`define CHANNEL_VALUE_FRAME_PARSER_TOP_MACROS_SVH

// Hold cond at every edge outside reset.
`define CVFP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When ante holds, cons must hold at the next edge.
`define CVFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/cvfp_pkg.sv
// ----------------------------------------------------------------------------
// cvfp_pkg
// Types and constants shared by the channel/value frame parser.
// ----------------------------------------------------------------------------
package cvfp_pkg;

  localparam int BUFFER_SIZE_DEFAULT = 512;

  localparam int CHAN_W  = 9;
  localparam int VALUE_W = 8;
  localparam int BYTE_W  = 8;
  localparam int TICK_W  = 16;
  localparam int PAY_W   = 6;

  // Event codes
  localparam logic [1:0] CMD_RX_BYTE  = 2'd0;
  localparam logic [1:0] CMD_LINE_ERR = 2'd1;
  localparam logic [1:0] CMD_BUTTON   = 2'd2;

  // Byte tags, bits 7..6
  localparam logic [1:0] TAG_FIRST  = 2'b00;
  localparam logic [1:0] TAG_SECOND = 2'b01;
  localparam logic [1:0] TAG_THIRD  = 2'b11;

  localparam logic [TICK_W-1:0] TICK_BUTTON = 16'h7fff;

  typedef struct packed {
    logic [1:0]        command;
    logic [BYTE_W-1:0] rx_byte;
    logic              tx_ready;
  } cmd_item_t;

  typedef struct packed {
    logic               write_valid;
    logic [CHAN_W-1:0]  write_channel;
    logic [VALUE_W-1:0] write_value;
    logic               echo_valid;
    logic [BYTE_W-1:0]  echo_byte;
    logic               error_led;
    logic               activity_led;
  } res_item_t;

endpackage

FILE: hdl/cvfp_cmd_if.sv
// ----------------------------------------------------------------------------
// cvfp_cmd_if
// Event channel: valid/ready handshake carrying one serial event per beat.
// ----------------------------------------------------------------------------
interface cvfp_cmd_if
  import cvfp_pkg::*;
();
  logic      valid;
  logic      ready;
  cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/cvfp_res_if.sv
// ----------------------------------------------------------------------------
// cvfp_res_if
// Result channel: valid/ready handshake carrying one result per beat.
// ----------------------------------------------------------------------------
interface cvfp_res_if
  import cvfp_pkg::*;
();
  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/channel_value_frame_parser_top.sv
// ----------------------------------------------------------------------------
// channel_value_frame_parser_top
// Parses three-byte channel/value frames out of a stream of serial events.
// ----------------------------------------------------------------------------
// Output: a result beat appears in the cycle after its event beat is accepted.
// Flow: one event per cycle unless the result register is full and the sink
//   stalls; the result register frees itself whenever the sink takes its beat.
// Reset: synchronous, active high; clears the frame phase, accumulators, the
//   error tick and both lamps, and empties the result register.
// ----------------------------------------------------------------------------
`include "channel_value_frame_parser_top_macros.svh"

module channel_value_frame_parser_top
  import cvfp_pkg::*;
#(
  // Buffer depth; the written channel is ANDed with BUFFER_SIZE-1
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  cvfp_cmd_if.sink   cmd,
  cvfp_res_if.source res
);

  // Result register: one beat of storage between the frame logic and the sink
  logic      out_valid;
  res_item_t out_item;

  logic      accept;
  res_item_t step_result;

  // Take a new event whenever the result register is empty or being drained
  assign cmd.ready = !out_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  // Frame state advances only on an accepted event beat
  cvfp_frame_core #(
    .BUFFER_SIZE(BUFFER_SIZE)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (accept),
    .item  (cmd.data),
    .result(step_result)
  );

  // Load on accept, drop once the sink takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= step_result;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_item;

  // Every accepted event yields a result beat on the next cycle
  `CVFP_ASSERT_NEXT(a_accept_gives_beat, accept, res.valid, "accepted event produced no result")

  // An echo is only sent as part of a completed frame
  `CVFP_ASSERT_ALWAYS(a_echo_needs_write, !(res.valid && res.data.echo_valid) || res.data.write_valid, "echo without a frame write")

  // Channel and value fields read zero when no write happens
  `CVFP_ASSERT_ALWAYS(a_idle_write_zero, !(res.valid && !res.data.write_valid) || (res.data.write_channel == '0 && res.data.write_value == '0), "write fields nonzero without write")

  // Echo byte reads zero when no echo is sent
  `CVFP_ASSERT_ALWAYS(a_idle_echo_zero, !(res.valid && !res.data.echo_valid) || (res.data.echo_byte == '0), "echo byte nonzero without echo")

endmodule

FILE: hdl/cvfp_frame_core.sv
// ----------------------------------------------------------------------------
// cvfp_frame_core
// Frame state and the per-event result, advanced once per accepted beat.
// ----------------------------------------------------------------------------
module cvfp_frame_core
  import cvfp_pkg::*;
#(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  cmd_item_t item,
  output res_item_t result
);

  localparam logic [CHAN_W-1:0] ChanMask = CHAN_W'(BUFFER_SIZE - 1);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  phase_t              phase, phase_next;
  logic [CHAN_W-1:0]   chan_acc, chan_acc_next;
  logic [VALUE_W-1:0]  value_acc, value_acc_next;
  logic [TICK_W-1:0]   ticks, ticks_next;
  logic                err_lamp, err_lamp_next;
  logic                act_lamp, act_lamp_next;

  logic [1:0]          tag;
  logic [PAY_W-1:0]    pay;
  logic                tag_ok;
  logic [TICK_W-1:0]   tick_base;
  logic [VALUE_W-1:0]  value_full;

  assign tag        = item.rx_byte[7:6];
  assign pay        = item.rx_byte[PAY_W-1:0];
  assign value_full = value_acc | {2'b00, pay};

  always_comb begin
    unique case (phase)
      PH_FIRST:  tag_ok = (tag == TAG_FIRST);
      PH_SECOND: tag_ok = (tag == TAG_SECOND);
      PH_THIRD:  tag_ok = (tag == TAG_THIRD);
      default:   tag_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_next     = phase;
    chan_acc_next  = chan_acc;
    value_acc_next = value_acc;
    ticks_next     = ticks;
    err_lamp_next  = err_lamp;
    act_lamp_next  = act_lamp;
    tick_base      = ticks;
    result         = '0;

    unique case (item.command)
      CMD_RX_BYTE: begin
        if (!tag_ok) begin
          // drop the byte and restart the frame
          phase_next    = PH_FIRST;
          err_lamp_next = 1'b1;
          tick_base     = '0;
        end else begin
          unique case (phase)
            PH_FIRST: begin
              chan_acc_next  = {pay, 3'b000};
              value_acc_next = '0;
              phase_next     = PH_SECOND;
            end
            PH_SECOND: begin
              chan_acc_next  = chan_acc | {5'b00000, pay[5:2]};
              value_acc_next = {pay[1:0], 6'b000000};
              phase_next     = PH_THIRD;
            end
            default: begin
              value_acc_next       = value_full;
              result.write_valid   = 1'b1;
              result.write_channel = chan_acc & ChanMask;
              result.write_value   = value_full;
              if (item.tx_ready) begin
                result.echo_valid = 1'b1;
                result.echo_byte  = chan_acc[BYTE_W-1:0];
              end
              act_lamp_next = ~act_lamp;
              phase_next    = PH_FIRST;
            end
          endcase
        end
        ticks_next = tick_base + TICK_W'(1);
        if (ticks_next == '0) begin
          err_lamp_next = 1'b0;
        end
      end
      CMD_LINE_ERR: begin
        phase_next    = PH_FIRST;
        err_lamp_next = 1'b1;
        ticks_next    = '0;
      end
      CMD_BUTTON: begin
        err_lamp_next = 1'b1;
        ticks_next    = TICK_BUTTON;
      end
      default: begin
      end
    endcase

    result.error_led    = err_lamp_next;
    result.activity_led = act_lamp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      chan_acc  <= '0;
      value_acc <= '0;
      ticks     <= '0;
      err_lamp  <= 1'b0;
      act_lamp  <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      chan_acc  <= chan_acc_next;
      value_acc <= value_acc_next;
      ticks     <= ticks_next;
      err_lamp  <= err_lamp_next;
      act_lamp  <= act_lamp_next;
    end
  end

endmodule

FILE: tb/cvfp_frame_checker.sv
// ----------------------------------------------------------------------------
// cvfp_frame_checker
// Watches the event and result channels of the frame parser, keeps its own
// copy of the frame state, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module cvfp_frame_checker
  import cvfp_pkg::*;
#(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  cvfp_cmd_if  cmd,
  cvfp_res_if  res,
  output int   mismatches,
  output int   outstanding,
  output int   frames_written,
  output int   echoes_sent,
  output int   lamp_clears
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [CHAN_W-1:0] CHAN_MASK = CHAN_W'(BUFFER_SIZE - 1);

  logic [1:0]         phase;
  logic [CHAN_W-1:0]  chan_acc;
  logic [VALUE_W-1:0] val_acc;
  logic [TICK_W-1:0]  ticks;
  logic               err_lamp;
  logic               act_lamp;

  res_item_t frame_results_q[$];
  res_item_t want;
  res_item_t got;
  int        err_count;
  int        write_count;
  int        echo_count;
  int        clear_count;

  function automatic void reset_frame_state();
    phase    = PH_FIRST;
    chan_acc = '0;
    val_acc  = '0;
    ticks    = '0;
    err_lamp = 1'b0;
    act_lamp = 1'b0;
  endfunction

  // Line error or bad tag: restart the frame, light the lamp, clear the tick
  function automatic void restart_frame();
    phase    = PH_FIRST;
    err_lamp = 1'b1;
    ticks    = '0;
  endfunction

  function automatic res_item_t parse_event(cmd_item_t ev);
    res_item_t        r;
    logic [1:0]       tag;
    logic [PAY_W-1:0] pay;
    logic             tag_ok;
    r   = '0;
    tag = ev.rx_byte[7:6];
    pay = ev.rx_byte[PAY_W-1:0];
    case (ev.command)
      CMD_RX_BYTE: begin
        case (phase)
          PH_FIRST:  tag_ok = (tag == TAG_FIRST);
          PH_SECOND: tag_ok = (tag == TAG_SECOND);
          PH_THIRD:  tag_ok = (tag == TAG_THIRD);
          default:   tag_ok = 1'b0;
        endcase
        if (!tag_ok) begin
          restart_frame();
        end else if (phase == PH_FIRST) begin
          chan_acc = {pay, 3'b000};
          val_acc  = '0;
          phase    = PH_SECOND;
        end else if (phase == PH_SECOND) begin
          chan_acc = chan_acc | {5'b0, pay[5:2]};
          val_acc  = {pay[1:0], 6'b0};
          phase    = PH_THIRD;
        end else begin
          val_acc         = val_acc | {2'b0, pay};
          r.write_valid   = 1'b1;
          r.write_channel = chan_acc & CHAN_MASK;
          r.write_value   = val_acc;
          write_count++;
          if (ev.tx_ready) begin
            r.echo_valid = 1'b1;
            r.echo_byte  = chan_acc[BYTE_W-1:0];
            echo_count++;
          end
          act_lamp = ~act_lamp;
          phase    = PH_FIRST;
        end
        // Every byte counts, good or dropped
        ticks = ticks + TICK_W'(1);
        if (ticks == '0) begin
          if (err_lamp) clear_count++;
          err_lamp = 1'b0;
        end
      end
      CMD_LINE_ERR: restart_frame();
      CMD_BUTTON: begin
        err_lamp = 1'b1;
        ticks    = TICK_BUTTON;
      end
      default: ;
    endcase
    r.error_led    = err_lamp;
    r.activity_led = act_lamp;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
    end
  endtask

  initial begin
    reset_frame_state();
    err_count   = 0;
    write_count = 0;
    echo_count  = 0;
    clear_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      reset_frame_state();
      frame_results_q.delete();
    end else begin
      // Compare before queuing: a result never answers the event of the same edge
      if (res.valid && res.ready) begin
        got = res.data;
        if (frame_results_q.size() == 0) begin
          err_count++;
          $error("result beat with no event outstanding");
        end else begin
          want = frame_results_q.pop_front();
          check_field("write_valid",   16'(want.write_valid),   16'(got.write_valid));
          check_field("write_channel", 16'(want.write_channel), 16'(got.write_channel));
          check_field("write_value",   16'(want.write_value),   16'(got.write_value));
          check_field("echo_valid",    16'(want.echo_valid),    16'(got.echo_valid));
          check_field("echo_byte",     16'(want.echo_byte),     16'(got.echo_byte));
          check_field("error_led",     16'(want.error_led),     16'(got.error_led));
          check_field("activity_led",  16'(want.activity_led),  16'(got.activity_led));
        end
      end
      if (cmd.valid && cmd.ready) frame_results_q.push_back(parse_event(cmd.data));
    end
    mismatches     <= err_count;
    outstanding    <= frame_results_q.size();
    frames_written <= write_count;
    echoes_sent    <= echo_count;
    lamp_clears    <= clear_count;
  end

endmodule

FILE: tb/channel_value_frame_parser_top_test.sv
// ----------------------------------------------------------------------------
// channel_value_frame_parser_top_test
// Drives serial events into the frame parser with random idle and stall
// bursts; a side checker predicts each result beat and counts mismatches.
// ----------------------------------------------------------------------------
module channel_value_frame_parser_top_test;
  import cvfp_pkg::*;

  // Event code the block ignores; not named in the package
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam int RANDOM_EVENTS = 1525;
  // Drop all idling for the final stretch of the random part
  localparam int QUIET_TAIL    = 200;
  localparam int STALL_LIMIT   = 500;
  localparam int DRAIN_CYCLES  = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   idle_on;
  int   event_count;
  int   stall_count;
  int   stall_left;

  int mismatches;
  int outstanding;
  int frames_written;
  int echoes_sent;
  int lamp_clears;

  cvfp_cmd_if cmd_ch ();
  cvfp_res_if res_ch ();

  channel_value_frame_parser_top uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  cvfp_frame_checker chk (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_ch),
    .res            (res_ch),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .frames_written (frames_written),
    .echoes_sent    (echoes_sent),
    .lamp_clears    (lamp_clears)
  );

  always #5 clk = ~clk;

  // Result sink: hold ready low for random bursts while idling is on,
  // otherwise keep it high outside reset. One assignment per falling edge.
  initial begin
    res_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (idle_on && !rst && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= !rst;
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst) begin
      stall_count <= 0;
    end else if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("channel_value_frame_parser_top_test: errors");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Present one event beat and hold it until the block takes it. Called at a
  // falling edge; returns at the falling edge after acceptance, so valid
  // stays high across back-to-back beats without a second assignment.
  task automatic send_event(logic [1:0] command, logic [BYTE_W-1:0] rx_byte,
                            logic tx_ready);
    cmd_item_t item;
    int        gap;
    item.command  = command;
    item.rx_byte  = rx_byte;
    item.tx_ready = tx_ready;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= item;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    event_count++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] rx_byte);
    send_event(CMD_RX_BYTE, rx_byte, 1'($urandom_range(0, 1)));
  endtask

  // Split channel and value over the three tagged bytes. Channel bit 3 comes
  // from both the first and the second byte; the block ORs them.
  task automatic send_frame(logic [CHAN_W-1:0] chan, logic [VALUE_W-1:0] val,
                            logic tx_ready);
    send_event(CMD_RX_BYTE, {TAG_FIRST, chan[8:3]}, 1'($urandom_range(0, 1)));
    send_event(CMD_RX_BYTE, {TAG_SECOND, chan[3:0], val[7:6]}, 1'($urandom_range(0, 1)));
    send_event(CMD_RX_BYTE, {TAG_THIRD, val[5:0]}, tx_ready);
  endtask

  task automatic send_random_frame();
    send_frame(CHAN_W'($urandom), VALUE_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Noise and broken frames for the random part
  task automatic send_disturbance();
    logic [BYTE_W-1:0] b;
    int                kind;
    kind = $urandom_range(0, 3);
    case (kind)
      0: begin
        // Truncate a frame after one or two good bytes, then send a random event
        b = BYTE_W'($urandom);
        send_byte({TAG_FIRST, b[5:0]});
        if ($urandom_range(0, 1)) send_byte({TAG_SECOND, b[5:0]});
        send_event(2'($urandom_range(0, 3)), BYTE_W'($urandom), 1'($urandom_range(0, 1)));
      end
      1: begin
        // Frame whose second and third bytes carry random tags; mostly wrong
        b = BYTE_W'($urandom);
        send_byte({TAG_FIRST, b[5:0]});
        send_byte({2'($urandom), b[5:0]});
        send_byte({2'($urandom), b[5:0]});
      end
      2: begin
        // Button in the middle of an otherwise good frame
        b = BYTE_W'($urandom);
        send_byte({TAG_FIRST, b[5:0]});
        send_event(CMD_BUTTON, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
        send_byte({TAG_SECOND, b[5:0]});
        send_byte({TAG_THIRD, b[5:0]});
      end
      default: begin
        send_event(2'($urandom_range(0, 3)), BYTE_W'($urandom), 1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  initial begin
    int random_start;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    idle_on      = 1'b0;
    event_count  = 0;

    // Hold reset, then release it at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    idle_on = 1'b1;

    // Directed: all-zero and all-one frames, then echo withheld
    send_frame(9'h000, 8'h00, 1'b1);
    send_frame(9'h1ff, 8'hff, 1'b1);
    send_frame(9'h0aa, 8'h55, 1'b0);
    // Bad tags: third tag first, reserved tag first, wrong second, wrong third
    send_event(CMD_RX_BYTE, {TAG_THIRD, 6'h15}, 1'b1);
    send_event(CMD_RX_BYTE, 8'h80, 1'b0);
    send_byte({TAG_FIRST, 6'h3f});
    send_byte({TAG_FIRST, 6'h00});
    send_byte({TAG_FIRST, 6'h01});
    send_byte({TAG_SECOND, 6'h3e});
    send_byte({TAG_SECOND, 6'h01});
    // Line error mid-frame; the following second byte is then out of order
    send_byte({TAG_FIRST, 6'h05});
    send_event(CMD_LINE_ERR, 8'hff, 1'b1);
    send_byte({TAG_SECOND, 6'h2a});
    // Button mid-frame leaves the frame intact
    send_byte({TAG_FIRST, 6'h11});
    send_event(CMD_BUTTON, 8'ha5, 1'b0);
    send_byte({TAG_SECOND, 6'h12});
    // Reserved code mid-frame changes nothing
    send_event(CMD_RESERVED, 8'hff, 1'b1);
    send_byte({TAG_THIRD, 6'h23});

    // Random part: mostly good frames with random content, the rest noise
    random_start = event_count;
    while (event_count - random_start < RANDOM_EVENTS) begin
      if (event_count - random_start >= RANDOM_EVENTS - QUIET_TAIL) idle_on = 1'b0;
      if ($urandom_range(0, 9) < 7) send_random_frame();
      else send_disturbance();
    end

    // Drain: drop valid, wait out every outstanding result, then settle
    idle_on = 1'b0;
    cmd_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d events; %0d frames written, %0d of them echoed.",
             event_count, frames_written, echoes_sent);
    $display("Error lamp put out by tick wrap %0d time(s).", lamp_clears);
    if (mismatches == 0 && outstanding == 0) begin
      $display("channel_value_frame_parser_top_test: clean");
    end else begin
      $display("channel_value_frame_parser_top_test: errors");
    end
    $finish;
  end

endmodule
